// ===== design/lpl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_pkg: shared types for the longest palindrome length block
// Command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lpl_pkg;

    // Largest value the 9-bit length field can carry.
    localparam int unsigned OUT_MAX = 511;
    localparam int unsigned OUT_W   = 9;

    typedef struct packed {
        logic load;       // store the accepted byte or mark overflow
        logic start;      // first center, best length back to one
        logic odd_init;   // window around the current center
        logic even_init;  // window between the center and its right neighbor
        logic step;       // widen the window by one on each side
        logic stop;       // fold the current window length into the best
        logic next_c;     // move to the next center
        logic finish;     // post the result and clear the buffer state
    } cmd_t;

    typedef struct packed {
        logic in_bounds;  // both window ends lie inside the stored string
        logic match;      // the two bytes read last cycle are equal
        logic c_done;     // every center has been visited
    } status_t;

endpackage

// ===== design/longest_palindrome_length_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_palindrome_length_top: longest palindromic substring length
// Buffers a string and reports the length of its longest palindrome.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle into a MAX_LEN-entry buffer; bytes past the
// capacity are dropped and flagged as truncated. After the byte marked last,
// input stalls while a sequencer expands a window around every center of the
// stored string. Each comparison is one buffer read and then one compare,
// and each center has its setup, then a read and a stop for the odd and for
// the even window. The result waits in an output register until transferred,
// and the next string loads as soon as the search has posted it. A search
// that ends while the previous result still waits holds until that transfer.
module longest_palindrome_length_top #(
    parameter int MAX_LEN = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_char_code,
    input  logic                      s_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [lpl_pkg::OUT_W-1:0] m_max_length,
    output logic                      m_truncated
);

    lpl_pkg::cmd_t    cmd;
    lpl_pkg::status_t status;

    lpl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lpl_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_char_code  (s_char_code),
        .cmd          (cmd),
        .status       (status),
        .m_max_length (m_max_length),
        .m_truncated  (m_truncated)
    );

`ifndef NO_ASSERTIONS
    // A posted length is never zero.
    a_len_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_max_length != '0))
        else $error("zero length posted");

    // The final byte stalls input for the search.
    a_last_stalls : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("input not stalled after final byte");

    // A new result only appears at the end of a search, never during loading.
    a_result_after_search : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result posted while loading");
`endif

endmodule

// ===== design/lpl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_ctrl: sequencer for the palindrome search
// Loads bytes, walks every center, expands each window and posts the result.
// ----------------------------------------------------------------------------
module lpl_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  lpl_pkg::status_t status,
    output lpl_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_LOAD    = 6'b000001,
        S_CENTER  = 6'b000010,
        S_CHECK   = 6'b000100,
        S_COMPARE = 6'b001000,
        S_STOP    = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   even_reg, even_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            even_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            even_reg    <= even_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        even_next    = even_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last) begin
                        cmd.start  = 1'b1;
                        state_next = S_CENTER;
                    end
                end
            end
            S_CENTER: begin
                if (status.c_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.odd_init = 1'b1;
                    even_next    = 1'b0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                // The buffer read for this window is issued in this cycle.
                state_next = status.in_bounds ? S_COMPARE : S_STOP;
            end
            S_COMPARE: begin
                if (status.match) begin
                    cmd.step   = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    state_next = S_STOP;
                end
            end
            S_STOP: begin
                cmd.stop = 1'b1;
                if (!even_reg) begin
                    cmd.even_init = 1'b1;
                    even_next     = 1'b1;
                    state_next    = S_CHECK;
                end else begin
                    cmd.next_c = 1'b1;
                    state_next = S_CENTER;
                end
            end
            S_FINISH: begin
                // Hold until the previous result has been transferred.
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign s_ready = (state_reg == S_LOAD);
    assign m_valid = m_valid_reg;

endmodule

// ===== design/lpl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_datapath: byte buffer, window pointers and best length
// Holds the string in a two-read-port memory and tracks the search window.
// ----------------------------------------------------------------------------
module lpl_datapath #(
    parameter int MAX_LEN = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    s_char_code,
    input  lpl_pkg::cmd_t                 cmd,
    output lpl_pkg::status_t              status,
    output logic [lpl_pkg::OUT_W-1:0]     m_max_length,
    output logic                          m_truncated
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int IW = CW + 1;
    localparam logic [CW-1:0] CAP = CW'(MAX_LEN);

    logic [7:0]    mem [MAX_LEN];
    logic [7:0]    rd_l_reg, rd_r_reg;

    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] c_reg, c_next;
    logic [IW-1:0] l_reg, l_next;
    logic [IW-1:0] r_reg, r_next;
    logic [IW-1:0] best_reg, best_next;
    logic [IW-1:0] win_len;
    logic [IW-1:0] c_ext;
    logic [31:0]   best_wide;
    logic [lpl_pkg::OUT_W-1:0] m_max_length_reg;
    logic          m_truncated_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load && (fill_reg < CAP)) begin
            mem[fill_reg[AW-1:0]] <= s_char_code;
        end
        rd_l_reg <= mem[l_reg[AW-1:0]];
        rd_r_reg <= mem[r_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg    <= c_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        best_reg <= best_next;
    end

    assign c_ext   = {1'b0, c_reg};
    // Window ends are exclusive, so the palindrome spans r - l - 1 bytes.
    assign win_len = r_reg - l_reg - IW'(1);

    always_comb begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        c_next    = c_reg;
        l_next    = l_reg;
        r_next    = r_reg;
        best_next = best_reg;
        if (cmd.load) begin
            if (fill_reg < CAP) begin
                fill_next = fill_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.start) begin
            c_next    = '0;
            best_next = IW'(1);
        end
        if (cmd.odd_init) begin
            l_next = c_ext - IW'(1);
            r_next = c_ext + IW'(1);
        end
        if (cmd.even_init) begin
            l_next = c_ext;
            r_next = c_ext + IW'(1);
        end
        if (cmd.step) begin
            l_next = l_reg - IW'(1);
            r_next = r_reg + IW'(1);
        end
        if (cmd.stop && (win_len > best_reg)) begin
            best_next = win_len;
        end
        if (cmd.next_c) begin
            c_next = c_reg + CW'(1);
        end
        if (cmd.finish) begin
            fill_next = '0;
            ovf_next  = 1'b0;
        end
    end

    // A negative left end shows up as the sign bit of the wider pointer.
    assign status.in_bounds = !l_reg[IW-1] && (r_reg < {1'b0, fill_reg});
    assign status.match     = (rd_l_reg == rd_r_reg);
    assign status.c_done    = (c_reg >= fill_reg);

    assign best_wide = 32'(best_reg);

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_max_length_reg <= (best_wide > lpl_pkg::OUT_MAX)
                                ? lpl_pkg::OUT_W'(lpl_pkg::OUT_MAX)
                                : best_wide[lpl_pkg::OUT_W-1:0];
            m_truncated_reg  <= ovf_reg;
        end
    end

    assign m_max_length = m_max_length_reg;
    assign m_truncated  = m_truncated_reg;

endmodule
